### rtl/stnsg_pkg.sv
// Package for the square tone and noise sound generator: constants and attenuation table.
`default_nettype none
package stnsg_pkg;

    localparam int NumTones     = 3;
    localparam int PeriodWidth  = 10;
    localparam int AttenWidth   = 4;
    localparam int LevelWidth   = 13;
    localparam int SampleWidth  = 16;
    localparam int ShifterWidth = 16;
    localparam int ByteWidth    = 8;

    localparam logic [1:0] NoiseChannel = 2'd3;

    localparam logic [AttenWidth-1:0]   AttenSilent  = 4'hF;
    localparam logic [ShifterWidth-1:0] ShifterSeed  = 16'hFFFF;

    // noise rate codes
    localparam logic [1:0] RateFast = 2'd0;
    localparam logic [1:0] RateMid  = 2'd1;
    localparam logic [1:0] RateSlow = 2'd2;
    localparam logic [1:0] RateTone = 2'd3;

    localparam logic [PeriodWidth-1:0] ReloadFast = 10'h010;
    localparam logic [PeriodWidth-1:0] ReloadMid  = 10'h020;
    localparam logic [PeriodWidth-1:0] ReloadSlow = 10'h040;

    // beat kinds carried on tuser
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdTick  = 1'b1;

    // 2 dB steps, full scale 8191, last code silent
    function automatic logic [LevelWidth-1:0] atten_level(input logic [AttenWidth-1:0] a);
        logic [LevelWidth-1:0] v;
        case (a)
            4'd0:    v = 13'd8191;
            4'd1:    v = 13'd6506;
            4'd2:    v = 13'd5168;
            4'd3:    v = 13'd4105;
            4'd4:    v = 13'd3260;
            4'd5:    v = 13'd2590;
            4'd6:    v = 13'd2057;
            4'd7:    v = 13'd1634;
            4'd8:    v = 13'd1298;
            4'd9:    v = 13'd1031;
            4'd10:   v = 13'd819;
            4'd11:   v = 13'd650;
            4'd12:   v = 13'd516;
            4'd13:   v = 13'd410;
            4'd14:   v = 13'd326;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [SampleWidth-1:0] signed_level(
        input logic [AttenWidth-1:0] a,
        input logic                  bit_val
    );
        logic [SampleWidth-1:0] mag;
        mag = {{(SampleWidth-LevelWidth){1'b0}}, atten_level(a)};
        return bit_val ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

### rtl/square_tone_noise_sound_generator.sv
// Top level of the square tone and noise sound generator.
// A tick beat passes through the input register, then its sample is held in the output register on m_axis.
// Throughput: one beat per cycle, write or tick, under no backpressure.
// Write beats produce no output beat; the input register stalls only when a tick
// meets a full, stalled output register.
// Reset (synchronous, aresetn low) silences all channels, zeroes periods and counts
// and loads the noise shifter with all ones.
`default_nettype none
module square_tone_noise_sound_generator (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_axis_tvalid,
    output      logic                                   s_axis_tready,
    input  wire logic [stnsg_pkg::ByteWidth-1:0]        s_axis_tdata,  // [7:0] cmd_byte
    input  wire logic                                   s_axis_tuser,  // [0] cmd
    output      logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output      logic [stnsg_pkg::SampleWidth-1:0]      m_axis_tdata   // [15:0] sample
);
    import stnsg_pkg::*;

    // input register
    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [ByteWidth-1:0] in_byte_reg;

    // channel state
    logic [PeriodWidth-1:0]  tone_period_reg [NumTones];
    logic [PeriodWidth-1:0]  tone_count_reg  [NumTones];
    logic [NumTones-1:0]     tone_phase_reg;
    logic [AttenWidth-1:0]   tone_atten_reg  [NumTones];
    logic [PeriodWidth-1:0]  noise_count_reg;
    logic [AttenWidth-1:0]   noise_atten_reg;
    logic [1:0]              noise_rate_sel_reg;
    logic                    noise_half_phase_reg;
    logic                    noise_level_bit_reg;
    logic [ShifterWidth-1:0] noise_shifter_reg;
    logic [1:0]              latched_channel_reg;
    logic                    latched_is_volume_reg;

    logic [PeriodWidth-1:0]  tone_period_next [NumTones];
    logic [PeriodWidth-1:0]  tone_count_next  [NumTones];
    logic [NumTones-1:0]     tone_phase_next;
    logic [AttenWidth-1:0]   tone_atten_next  [NumTones];
    logic [PeriodWidth-1:0]  noise_count_next;
    logic [AttenWidth-1:0]   noise_atten_next;
    logic [1:0]              noise_rate_sel_next;
    logic                    noise_half_phase_next;
    logic                    noise_level_bit_next;
    logic [ShifterWidth-1:0] noise_shifter_next;
    logic [1:0]              latched_channel_next;
    logic                    latched_is_volume_next;

    // output register
    logic                   out_valid_reg;
    logic [SampleWidth-1:0] out_sample_reg;
    logic [SampleWidth-1:0] out_sample_next;

    logic out_free;
    logic advance;
    logic is_tick;

    assign is_tick       = (in_cmd_reg == CmdTick);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!is_tick || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;

    // command decode and tick update
    always_comb begin
        logic                      latch;
        logic [1:0]                ch;
        logic                      vol;
        logic signed [SampleWidth-1:0] sum;

        tone_period_next       = tone_period_reg;
        tone_count_next        = tone_count_reg;
        tone_phase_next        = tone_phase_reg;
        tone_atten_next        = tone_atten_reg;
        noise_count_next       = noise_count_reg;
        noise_atten_next       = noise_atten_reg;
        noise_rate_sel_next    = noise_rate_sel_reg;
        noise_half_phase_next  = noise_half_phase_reg;
        noise_level_bit_next   = noise_level_bit_reg;
        noise_shifter_next     = noise_shifter_reg;
        latched_channel_next   = latched_channel_reg;
        latched_is_volume_next = latched_is_volume_reg;
        sum                    = '0;

        latch = in_byte_reg[7];
        ch    = latch ? in_byte_reg[6:5] : latched_channel_reg;
        vol   = latch ? in_byte_reg[4]   : latched_is_volume_reg;

        if (!is_tick) begin
            latched_channel_next   = ch;
            latched_is_volume_next = vol;
            if (ch == NoiseChannel) begin
                if (vol) begin
                    noise_atten_next = in_byte_reg[3:0];
                end else begin
                    noise_rate_sel_next = in_byte_reg[1:0];
                end
            end else begin
                for (int i = 0; i < NumTones; i++) begin
                    if (ch == 2'(i)) begin
                        if (vol) begin
                            tone_atten_next[i] = in_byte_reg[3:0];
                        end else if (latch) begin
                            tone_period_next[i][3:0] = in_byte_reg[3:0];
                        end else begin
                            tone_period_next[i][9:4] = in_byte_reg[5:0];
                        end
                    end
                end
            end
        end else begin
            for (int i = 0; i < NumTones; i++) begin
                if (tone_count_reg[i] == '0) begin
                    tone_count_next[i] = tone_period_reg[i];
                    tone_phase_next[i] = !tone_phase_reg[i];
                end else begin
                    tone_count_next[i] = tone_count_reg[i] - 1'b1;
                end
                sum = sum + signed_level(tone_atten_reg[i], tone_phase_next[i]);
            end
            if (noise_count_reg == '0) begin
                case (noise_rate_sel_reg)
                    RateFast: noise_count_next = ReloadFast;
                    RateMid:  noise_count_next = ReloadMid;
                    RateSlow: noise_count_next = ReloadSlow;
                    RateTone: noise_count_next = tone_period_reg[NumTones-1];
                    default:  noise_count_next = ReloadFast;
                endcase
                noise_half_phase_next = !noise_half_phase_reg;
                if (noise_half_phase_next) begin
                    noise_level_bit_next = noise_shifter_reg[15];
                    noise_shifter_next   = {noise_shifter_reg[14:0],
                                            noise_shifter_reg[15] ^ noise_shifter_reg[12]};
                end
            end else begin
                noise_count_next = noise_count_reg - 1'b1;
            end
            sum = sum + signed_level(noise_atten_reg, noise_level_bit_next);
        end
        out_sample_next = sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            for (int i = 0; i < NumTones; i++) begin
                tone_period_reg[i] <= '0;
                tone_count_reg[i]  <= '0;
                tone_atten_reg[i]  <= AttenSilent;
            end
            tone_phase_reg        <= '0;
            noise_count_reg       <= '0;
            noise_atten_reg       <= AttenSilent;
            noise_rate_sel_reg    <= RateFast;
            noise_half_phase_reg  <= 1'b0;
            noise_level_bit_reg   <= 1'b0;
            noise_shifter_reg     <= ShifterSeed;
            latched_channel_reg   <= '0;
            latched_is_volume_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                tone_period_reg       <= tone_period_next;
                tone_count_reg        <= tone_count_next;
                tone_phase_reg        <= tone_phase_next;
                tone_atten_reg        <= tone_atten_next;
                noise_count_reg       <= noise_count_next;
                noise_atten_reg       <= noise_atten_next;
                noise_rate_sel_reg    <= noise_rate_sel_next;
                noise_half_phase_reg  <= noise_half_phase_next;
                noise_level_bit_reg   <= noise_level_bit_next;
                noise_shifter_reg     <= noise_shifter_next;
                latched_channel_reg   <= latched_channel_next;
                latched_is_volume_reg <= latched_is_volume_next;
            end
            if (advance && is_tick) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && is_tick) begin
            out_sample_reg <= out_sample_next;
        end
    end

    // a tick beat always lands in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_tick |=> m_axis_tvalid)
        else $error("tick beat produced no sample");

    // a write beat never raises the output valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_tick |=> !$rose(m_axis_tvalid))
        else $error("write beat produced a sample");

    // the noise shifter cannot lock up at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        noise_shifter_reg != '0)
        else $error("noise shifter reached zero");

    // a tick never waits while the output slot is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_free |-> advance)
        else $error("input stage stalled with free output");

endmodule
`default_nettype wire
